>>> src/legv8_instruction_decoder_assert.svh
// Assertion macros shared by the instruction decoder RTL.
// Each macro expects i_clk and i_rst_n in the enclosing module.
`ifndef LEGV8_INSTRUCTION_DECODER_ASSERT_SVH
`define LEGV8_INSTRUCTION_DECODER_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define LDEC_ASSERT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define LDEC_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> src/ldec_pkg.sv
// Shared types, constants and opcode table for the LEGv8 instruction decoder.
// No dependencies; used by ldec_decode, ldec_cell and the top level.
package ldec_pkg;

    localparam int LABEL_DEPTH = 128;
    localparam int LBL_IDX_W   = $clog2(LABEL_DEPTH);
    localparam int LBL_CNT_W   = $clog2(LABEL_DEPTH + 1);

    localparam int WORD_W = 32;
    localparam int TGT_W  = 26;
    localparam int REG_W  = 5;
    localparam int IMM_W  = 12;
    localparam int MNEM_W = 5;
    localparam int FMT_W  = 3;
    localparam int CODE_W = 11;

    localparam int NUM_OPS = 27;

    localparam logic [MNEM_W-1:0] OP_BCOND = 5'd7;
    localparam logic [MNEM_W-1:0] OP_LSL   = 5'd15;
    localparam logic [MNEM_W-1:0] OP_LSR   = 5'd16;
    localparam logic [REG_W-1:0]  COND_MAX = 5'd13;

    typedef enum logic [FMT_W-1:0] {
        FMT_R  = 3'd0,
        FMT_I  = 3'd1,
        FMT_D  = 3'd2,
        FMT_B  = 3'd3,
        FMT_CB = 3'd4
    } t_fmt;

    // Width of the opcode field compared against the top of the word.
    typedef enum logic [1:0] {
        OPW_11,
        OPW_10,
        OPW_8,
        OPW_6
    } t_opw;

    typedef struct packed {
        logic [CODE_W-1:0] code;
        t_opw              width;
        t_fmt              fmt;
    } t_op_entry;

    // Decoded word, before the label table has seen the target.
    typedef struct packed {
        logic              recognized;
        logic [MNEM_W-1:0] mnemonic;
        t_fmt              fmt;
        logic [REG_W-1:0]  reg_first;
        logic [REG_W-1:0]  reg_second;
        logic [REG_W-1:0]  reg_third;
        logic [IMM_W-1:0]  imm_value;
        logic [REG_W-1:0]  cond_code;
        logic [TGT_W-1:0]  target_field;
        logic              branch;
    } t_dec;

    // Search token walking down the label chain.
    typedef struct packed {
        logic                 vld;
        logic                 done;
        logic                 is_new;
        logic [TGT_W-1:0]     key;
        logic [LBL_CNT_W-1:0] idx;
    } t_tok;

    function automatic t_op_entry op_entry(input logic [MNEM_W-1:0] sel);
        t_op_entry e;
        unique case (sel)
            5'd0:    e = '{11'h458, OPW_11, FMT_R};   // ADD
            5'd1:    e = '{11'h244, OPW_10, FMT_I};   // ADDI
            5'd2:    e = '{11'h450, OPW_11, FMT_R};   // AND
            5'd3:    e = '{11'h248, OPW_10, FMT_I};   // ANDI
            5'd4:    e = '{11'h005, OPW_6,  FMT_B};   // B
            5'd5:    e = '{11'h025, OPW_6,  FMT_B};   // BL
            5'd6:    e = '{11'h6B0, OPW_11, FMT_R};   // BR
            5'd7:    e = '{11'h054, OPW_8,  FMT_CB};  // B.cond
            5'd8:    e = '{11'h0B5, OPW_8,  FMT_CB};  // CBNZ
            5'd9:    e = '{11'h0B4, OPW_8,  FMT_CB};  // CBZ
            5'd10:   e = '{11'h7FE, OPW_11, FMT_R};   // DUMP
            5'd11:   e = '{11'h650, OPW_11, FMT_R};   // EOR
            5'd12:   e = '{11'h348, OPW_10, FMT_I};   // EORI
            5'd13:   e = '{11'h7FF, OPW_11, FMT_R};   // HALT
            5'd14:   e = '{11'h7C2, OPW_11, FMT_D};   // LDUR
            5'd15:   e = '{11'h69B, OPW_11, FMT_R};   // LSL
            5'd16:   e = '{11'h69A, OPW_11, FMT_R};   // LSR
            5'd17:   e = '{11'h4D8, OPW_11, FMT_R};   // MUL
            5'd18:   e = '{11'h550, OPW_11, FMT_R};   // ORR
            5'd19:   e = '{11'h2C8, OPW_10, FMT_I};   // ORRI
            5'd20:   e = '{11'h7FC, OPW_11, FMT_R};   // PRNL
            5'd21:   e = '{11'h7FD, OPW_11, FMT_R};   // PRNT
            5'd22:   e = '{11'h7C0, OPW_11, FMT_D};   // STUR
            5'd23:   e = '{11'h658, OPW_11, FMT_R};   // SUB
            5'd24:   e = '{11'h344, OPW_10, FMT_I};   // SUBI
            5'd25:   e = '{11'h3C4, OPW_10, FMT_I};   // SUBIS
            5'd26:   e = '{11'h758, OPW_11, FMT_R};   // SUBS
            default: e = '{11'h000, OPW_11, FMT_R};
        endcase
        return e;
    endfunction

    function automatic logic op_match(input t_op_entry e, input logic [WORD_W-1:0] w);
        logic m;
        unique case (e.width)
            OPW_11:  m = (w[31:21] == e.code);
            OPW_10:  m = (w[31:22] == e.code[9:0]);
            OPW_8:   m = (w[31:24] == e.code[7:0]);
            OPW_6:   m = (w[31:26] == e.code[5:0]);
            default: m = 1'b0;
        endcase
        return m;
    endfunction

endpackage

>>> src/ldec_decode.sv
// Opcode match and field extraction for one LEGv8 word.
// Depends on ldec_pkg (opcode table, t_dec).
module ldec_decode (
    input  logic [ldec_pkg::WORD_W-1:0] i_word,
    output ldec_pkg::t_dec              o_dec
);
    import ldec_pkg::*;

    logic              w_hit;
    logic [MNEM_W-1:0] w_sel;
    t_op_entry         w_ent;

    // First matching entry in table order wins: scan from the bottom up.
    always_comb begin
        w_hit = 1'b0;
        w_sel = '0;
        for (int i = NUM_OPS - 1; i >= 0; i--) begin
            if (op_match(op_entry(MNEM_W'(i)), i_word)) begin
                w_hit = 1'b1;
                w_sel = MNEM_W'(i);
            end
        end
    end

    assign w_ent = op_entry(w_sel);

    always_comb begin
        o_dec = '0;
        if (w_hit) begin
            o_dec.recognized = 1'b1;
            o_dec.mnemonic   = w_sel;
            o_dec.fmt        = w_ent.fmt;
            unique case (w_ent.fmt)
                FMT_R: begin
                    o_dec.reg_first  = i_word[4:0];
                    o_dec.reg_second = i_word[9:5];
                    o_dec.reg_third  = i_word[20:16];
                    if (w_sel == OP_LSL || w_sel == OP_LSR) begin
                        o_dec.imm_value = {6'd0, i_word[15:10]};
                    end
                end
                FMT_I: begin
                    o_dec.reg_first  = i_word[4:0];
                    o_dec.reg_second = i_word[9:5];
                    o_dec.imm_value  = i_word[21:10];
                end
                FMT_D: begin
                    o_dec.reg_first  = i_word[4:0];
                    o_dec.reg_second = i_word[9:5];
                    o_dec.imm_value  = {{3{i_word[20]}}, i_word[20:12]};
                end
                FMT_B: begin
                    o_dec.target_field = i_word[25:0];
                    o_dec.branch       = 1'b1;
                end
                FMT_CB: begin
                    o_dec.target_field = {7'd0, i_word[23:5]};
                    o_dec.branch       = 1'b1;
                    if (w_sel == OP_BCOND) begin
                        o_dec.cond_code = i_word[4:0];
                        // Drop recognition for condition codes past LE.
                        if (i_word[4:0] > COND_MAX) begin
                            o_dec.recognized = 1'b0;
                        end
                    end else begin
                        o_dec.reg_first = i_word[4:0];
                    end
                end
                default: begin
                    o_dec.recognized = 1'b0;
                end
            endcase
        end
    end

endmodule

>>> src/ldec_cell.sv
// One label-table cell: holds one stored target and forwards the search token.
// Depends on ldec_pkg (t_tok, widths).
module ldec_cell (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic [ldec_pkg::LBL_CNT_W-1:0] i_count,
    input  ldec_pkg::t_tok                 i_tok,
    output ldec_pkg::t_tok                 o_tok
);
    import ldec_pkg::*;

    logic [TGT_W-1:0] r_entry;
    t_tok             r_tok;
    t_tok             n_tok;
    logic             w_live;
    logic             w_hit;
    logic             w_ins;

    // The token's idx equals this cell's position until the search resolves.
    assign w_live = i_tok.vld && !i_tok.done;
    assign w_hit  = (i_tok.idx < i_count) && (r_entry == i_tok.key);
    assign w_ins  = (i_tok.idx == i_count);

    always_comb begin
        n_tok = i_tok;
        if (w_live) begin
            if (w_hit) begin
                n_tok.done = 1'b1;
            end else if (w_ins) begin
                n_tok.done   = 1'b1;
                n_tok.is_new = 1'b1;
            end else begin
                n_tok.idx = i_tok.idx + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tok <= '0;
        end else begin
            r_tok <= n_tok;
        end
    end

    // Claim this slot when the token reaches the first free position.
    always_ff @(posedge i_clk) begin
        if (w_live && !w_hit && w_ins) begin
            r_entry <= i_tok.key;
        end
    end

    assign o_tok = r_tok;

endmodule

>>> src/legv8_instruction_decoder.sv
// LEGv8 instruction decoder with a persistent branch-label table, top level.
// Depends on ldec_pkg, ldec_decode, ldec_cell and the assertion macro header.
//
// Usage:
//   Present a 32-bit word on i_instr_word and raise start. The word is taken
//   at a rising edge where start is high and busy is low. Each word yields
//   exactly one result, shown on the o_* field ports for one cycle with
//   o_strobe high; the receiver has no way to hold it, so capture it then.
//
//   Non-branch words (R, I, D formats, and unmatched words) skip the label
//   table: the result appears the cycle after acceptance and busy stays low,
//   so such words can be issued every cycle while no branch search is busy.
//
//   Branch words (B, BL, CBZ, CBNZ, B.cond) send their target down a chain of
//   LABEL_DEPTH cells, one cell per cycle; each cell holds one stored target.
//   The token always runs the full chain, also once its search has resolved;
//   busy stays high until it leaves the last cell, and the result is
//   registered from the chain exit, so the chain length sets the delay.
//
//   Reset (synchronous, active low) empties the label table by clearing the
//   stored-label count and drops any token in flight. Stored targets are not
//   cleared; only slots below the count are ever compared.
`include "legv8_instruction_decoder_assert.svh"

module legv8_instruction_decoder (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  start,
    input  logic [ldec_pkg::WORD_W-1:0]           i_instr_word,
    output logic                                  busy,
    output logic                                  o_strobe,
    output logic                                  o_recognized,
    output logic [ldec_pkg::MNEM_W-1:0]           o_mnemonic,
    output logic [ldec_pkg::FMT_W-1:0]            o_format,
    output logic [ldec_pkg::REG_W-1:0]            o_reg_first,
    output logic [ldec_pkg::REG_W-1:0]            o_reg_second,
    output logic [ldec_pkg::REG_W-1:0]            o_reg_third,
    output logic signed [ldec_pkg::IMM_W-1:0]     o_imm_value,
    output logic [ldec_pkg::REG_W-1:0]            o_cond_code,
    output logic [ldec_pkg::TGT_W-1:0]            o_target_field,
    output logic [ldec_pkg::LBL_IDX_W-1:0]        o_label_index,
    output logic                                  o_label_new,
    output logic                                  o_table_full
);
    import ldec_pkg::*;

    // Decode of the incoming word.
    t_dec w_dec;

    // Token chain: entry 0 is the launch point, LABEL_DEPTH is the exit.
    t_tok                   w_tok [LABEL_DEPTH+1];
    t_tok                   w_exit;
    logic [LABEL_DEPTH-1:0] w_tok_vld;
    logic                   w_accept;

    // Control state.
    logic                 r_busy,  n_busy;
    logic [LBL_CNT_W-1:0] r_count, n_count;
    logic                 r_strobe, n_strobe;

    // Payload: the branch word parked while its target searches the chain,
    // and the result word being shown.
    t_dec                 r_dec,  n_dec;
    t_dec                 r_out,  n_out;
    logic [LBL_IDX_W-1:0] r_lidx, n_lidx;
    logic                 r_lnew, n_lnew;
    logic                 r_full, n_full;

    ldec_decode u_decode (
        .i_word (i_instr_word),
        .o_dec  (w_dec)
    );

    assign w_accept = start && !r_busy;

    // Launch a search token only for branch words.
    always_comb begin
        w_tok[0]        = '0;
        w_tok[0].vld    = w_accept && w_dec.branch;
        w_tok[0].key    = w_dec.target_field;
    end

    for (genvar k = 0; k < LABEL_DEPTH; k++) begin : g_cell
        ldec_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_count (r_count),
            .i_tok   (w_tok[k]),
            .o_tok   (w_tok[k+1])
        );
        assign w_tok_vld[k] = w_tok[k+1].vld;
    end

    assign w_exit = w_tok[LABEL_DEPTH];

    always_comb begin
        n_busy   = r_busy;
        n_count  = r_count;
        n_strobe = 1'b0;
        n_dec    = r_dec;
        n_out    = r_out;
        n_lidx   = r_lidx;
        n_lnew   = r_lnew;
        n_full   = r_full;

        if (w_accept) begin
            n_dec = w_dec;
            if (w_dec.branch) begin
                // Hold the decode until the label search returns.
                n_busy = 1'b1;
            end else begin
                n_strobe = 1'b1;
                n_out    = w_dec;
                n_lidx   = '0;
                n_lnew   = 1'b0;
                n_full   = 1'b0;
            end
        end

        // A token leaving the chain unresolved means the table is full.
        if (w_exit.vld) begin
            n_busy   = 1'b0;
            n_strobe = 1'b1;
            n_out    = r_dec;
            n_lnew   = w_exit.is_new;
            n_full   = !w_exit.done;
            n_lidx   = w_exit.done ? w_exit.idx[LBL_IDX_W-1:0] : '0;
            if (w_exit.is_new) begin
                n_count = r_count + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy   <= 1'b0;
            r_count  <= '0;
            r_strobe <= 1'b0;
        end else begin
            r_busy   <= n_busy;
            r_count  <= n_count;
            r_strobe <= n_strobe;
        end
    end

    always_ff @(posedge i_clk) begin
        r_dec  <= n_dec;
        r_out  <= n_out;
        r_lidx <= n_lidx;
        r_lnew <= n_lnew;
        r_full <= n_full;
    end

    assign busy           = r_busy;
    assign o_strobe       = r_strobe;
    assign o_recognized   = r_out.recognized;
    assign o_mnemonic     = r_out.mnemonic;
    assign o_format       = r_out.fmt;
    assign o_reg_first    = r_out.reg_first;
    assign o_reg_second   = r_out.reg_second;
    assign o_reg_third    = r_out.reg_third;
    assign o_imm_value    = r_out.imm_value;
    assign o_cond_code    = r_out.cond_code;
    assign o_target_field = r_out.target_field;
    assign o_label_index  = r_lidx;
    assign o_label_new    = r_lnew;
    assign o_table_full   = r_full;

    `LDEC_ASSERT(a_one_token, 1'b1, $onehot0(w_tok_vld), "more than one search token in flight")
    `LDEC_ASSERT(a_token_busy, w_tok_vld != '0, r_busy, "search token present while not busy")
    `LDEC_ASSERT_NEXT(a_exit_result, w_exit.vld, r_strobe && !r_busy, "chain exit gave no result")
    `LDEC_ASSERT_NEXT(a_plain_result, w_accept && !w_dec.branch, r_strobe && !r_lnew && !r_full, "non-branch word result missing")
    `LDEC_ASSERT(a_count_bound, 1'b1, r_count <= LBL_CNT_W'(LABEL_DEPTH), "label count past table depth")

endmodule

>>> tb/legv8_instruction_decoder_test.sv
`timescale 1ns / 1ps
// Self-checking testbench for the LEGv8 instruction decoder and its branch-label table.
// Depends on ldec_pkg and the legv8_instruction_decoder top level; needs nothing else.
module legv8_instruction_decoder_test;
    import ldec_pkg::*;

    // Worst sender gap, and how long the watchdog tolerates a silent bus.
    // A branch word keeps busy high for a full pass down the label chain.
    localparam int MAX_GAP       = 20;
    localparam int QUIET_LIMIT   = 8 * (LABEL_DEPTH + 1 + MAX_GAP);
    localparam int PHASE_WORDS   = 275;

    // Mnemonic numbers in opcode table order.
    typedef enum logic [MNEM_W-1:0] {
        MN_ADD, MN_ADDI, MN_AND, MN_ANDI, MN_B, MN_BL, MN_BR, MN_BCOND, MN_CBNZ,
        MN_CBZ, MN_DUMP, MN_EOR, MN_EORI, MN_HALT, MN_LDUR, MN_LSL, MN_LSR,
        MN_MUL, MN_ORR, MN_ORRI, MN_PRNL, MN_PRNT, MN_STUR, MN_SUB, MN_SUBI,
        MN_SUBIS, MN_SUBS
    } t_mnem;

    typedef struct packed {
        logic [10:0] code;
        logic [3:0]  wid;
        t_fmt        f;
    } t_opcode;

    // Field order matches the port concatenation in the monitor below.
    typedef struct packed {
        logic                 recognized;
        logic [MNEM_W-1:0]    mnemonic;
        t_fmt                 fmt;
        logic [REG_W-1:0]     reg_first;
        logic [REG_W-1:0]     reg_second;
        logic [REG_W-1:0]     reg_third;
        logic [IMM_W-1:0]     imm_value;
        logic [REG_W-1:0]     cond_code;
        logic [TGT_W-1:0]     target_field;
        logic [LBL_IDX_W-1:0] label_index;
        logic                 label_new;
        logic                 table_full;
    } t_decoded;

    function automatic t_opcode op_info(input t_mnem m);
        t_opcode e;
        case (m)
            MN_ADD:   e = '{11'h458, 4'd11, FMT_R};
            MN_ADDI:  e = '{11'h244, 4'd10, FMT_I};
            MN_AND:   e = '{11'h450, 4'd11, FMT_R};
            MN_ANDI:  e = '{11'h248, 4'd10, FMT_I};
            MN_B:     e = '{11'h005, 4'd6,  FMT_B};
            MN_BL:    e = '{11'h025, 4'd6,  FMT_B};
            MN_BR:    e = '{11'h6B0, 4'd11, FMT_R};
            MN_BCOND: e = '{11'h054, 4'd8,  FMT_CB};
            MN_CBNZ:  e = '{11'h0B5, 4'd8,  FMT_CB};
            MN_CBZ:   e = '{11'h0B4, 4'd8,  FMT_CB};
            MN_DUMP:  e = '{11'h7FE, 4'd11, FMT_R};
            MN_EOR:   e = '{11'h650, 4'd11, FMT_R};
            MN_EORI:  e = '{11'h348, 4'd10, FMT_I};
            MN_HALT:  e = '{11'h7FF, 4'd11, FMT_R};
            MN_LDUR:  e = '{11'h7C2, 4'd11, FMT_D};
            MN_LSL:   e = '{11'h69B, 4'd11, FMT_R};
            MN_LSR:   e = '{11'h69A, 4'd11, FMT_R};
            MN_MUL:   e = '{11'h4D8, 4'd11, FMT_R};
            MN_ORR:   e = '{11'h550, 4'd11, FMT_R};
            MN_ORRI:  e = '{11'h2C8, 4'd10, FMT_I};
            MN_PRNL:  e = '{11'h7FC, 4'd11, FMT_R};
            MN_PRNT:  e = '{11'h7FD, 4'd11, FMT_R};
            MN_STUR:  e = '{11'h7C0, 4'd11, FMT_D};
            MN_SUB:   e = '{11'h658, 4'd11, FMT_R};
            MN_SUBI:  e = '{11'h344, 4'd10, FMT_I};
            MN_SUBIS: e = '{11'h3C4, 4'd10, FMT_I};
            default:  e = '{11'h758, 4'd11, FMT_R};
        endcase
        return e;
    endfunction

    // Tracks the decoder: owns its own copy of the label table, predicts each
    // accepted word and holds the predictions until the results show up.
    class decode_tracker;
        t_decoded             pending_decodes[$];
        logic [TGT_W-1:0]     label_store[LABEL_DEPTH];
        int unsigned          label_used;
        int unsigned          words, branches, full_hits, results, mismatches;

        function t_decoded decode_word(logic [WORD_W-1:0] w);
            t_decoded    d;
            t_opcode     e;
            int          hit;
            logic [8:0]  off;
            bit          found;
            d = '0;
            hit = -1;
            // First table entry wins; each entry compares at its own width.
            for (int i = 0; i < NUM_OPS; i++) begin
                e = op_info(t_mnem'(i));
                if (hit < 0 && (w >> (32 - e.wid)) == 32'(e.code))
                    hit = i;
            end
            if (hit < 0)
                return d;
            e = op_info(t_mnem'(hit));
            d.recognized = 1'b1;
            d.mnemonic   = 5'(hit);
            d.fmt        = e.f;
            case (e.f)
                FMT_R: begin
                    d.reg_first  = w[4:0];
                    d.reg_second = w[9:5];
                    d.reg_third  = w[20:16];
                    if (t_mnem'(hit) == MN_LSL || t_mnem'(hit) == MN_LSR)
                        d.imm_value = {6'b0, w[15:10]};
                end
                FMT_I: begin
                    d.reg_first  = w[4:0];
                    d.reg_second = w[9:5];
                    d.imm_value  = w[21:10];
                end
                FMT_D: begin
                    off          = w[20:12];
                    d.reg_first  = w[4:0];
                    d.reg_second = w[9:5];
                    d.imm_value  = {{3{off[8]}}, off};
                end
                default: begin
                    if (e.f == FMT_B) begin
                        d.target_field = w[25:0];
                    end else begin
                        d.target_field = {7'b0, w[23:5]};
                        if (t_mnem'(hit) == MN_BCOND) begin
                            d.cond_code = w[4:0];
                            if (d.cond_code > COND_MAX)
                                d.recognized = 1'b0;
                        end else begin
                            d.reg_first = w[4:0];
                        end
                    end
                    // B and CB targets share the table and compare as raw values.
                    found = 1'b0;
                    for (int k = 0; k < label_used; k++) begin
                        if (!found && label_store[k] == d.target_field) begin
                            found = 1'b1;
                            d.label_index = LBL_IDX_W'(k);
                        end
                    end
                    if (!found) begin
                        if (label_used >= LABEL_DEPTH) begin
                            d.table_full = 1'b1;
                            full_hits++;
                        end else begin
                            label_store[label_used] = d.target_field;
                            d.label_index = LBL_IDX_W'(label_used);
                            d.label_new = 1'b1;
                            label_used++;
                        end
                    end
                    branches++;
                end
            endcase
            return d;
        endfunction

        function void note_word(logic [WORD_W-1:0] w);
            words++;
            pending_decodes.push_back(decode_word(w));
        endfunction

        function void check_field(string name, logic [31:0] want, logic [31:0] got);
            if (got !== want) begin
                mismatches++;
                $display("%0t %s mismatch: expected %0h, actual %0h",
                         $time, name, want, got);
            end
        endfunction

        function void check_decode(t_decoded got);
            t_decoded want;
            if (pending_decodes.size() == 0) begin
                mismatches++;
                $display("%0t result with no word outstanding: expected none, actual %0h",
                         $time, got);
                return;
            end
            want = pending_decodes.pop_front();
            results++;
            check_field("recognized",   want.recognized,   got.recognized);
            check_field("mnemonic",     want.mnemonic,     got.mnemonic);
            check_field("format",       want.fmt,          got.fmt);
            check_field("reg_first",    want.reg_first,    got.reg_first);
            check_field("reg_second",   want.reg_second,   got.reg_second);
            check_field("reg_third",    want.reg_third,    got.reg_third);
            check_field("imm_value",    want.imm_value,    got.imm_value);
            check_field("cond_code",    want.cond_code,    got.cond_code);
            check_field("target_field", want.target_field, got.target_field);
            check_field("label_index",  want.label_index,  got.label_index);
            check_field("label_new",    want.label_new,    got.label_new);
            check_field("table_full",   want.table_full,   got.table_full);
        endfunction

        function void close_out();
            if (pending_decodes.size() != 0) begin
                mismatches += pending_decodes.size();
                $display("%0t results missing: expected %0d more, actual 0",
                         $time, pending_decodes.size());
            end
        endfunction
    endclass

    logic                 i_clk = 1'b0;
    logic                 i_rst_n;
    logic                 start;
    logic [WORD_W-1:0]    i_instr_word;
    logic                 busy;
    logic                 o_strobe;
    logic                 o_recognized;
    logic [MNEM_W-1:0]    o_mnemonic;
    logic [FMT_W-1:0]     o_format;
    logic [REG_W-1:0]     o_reg_first;
    logic [REG_W-1:0]     o_reg_second;
    logic [REG_W-1:0]     o_reg_third;
    logic signed [IMM_W-1:0] o_imm_value;
    logic [REG_W-1:0]     o_cond_code;
    logic [TGT_W-1:0]     o_target_field;
    logic [LBL_IDX_W-1:0] o_label_index;
    logic                 o_label_new;
    logic                 o_table_full;

    decode_tracker tracker = new();
    logic [TGT_W-1:0] seen_targets[$];
    int               quiet_cycles;

    // Receiver cannot stall, so the receiver-only phase runs the sender flat out
    // and the mixed phase keeps only the sender's share of idling.
    int idle_pct[4] = '{0, 49, 0, 38};

    legv8_instruction_decoder u_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .i_instr_word   (i_instr_word),
        .busy           (busy),
        .o_strobe       (o_strobe),
        .o_recognized   (o_recognized),
        .o_mnemonic     (o_mnemonic),
        .o_format       (o_format),
        .o_reg_first    (o_reg_first),
        .o_reg_second   (o_reg_second),
        .o_reg_third    (o_reg_third),
        .o_imm_value    (o_imm_value),
        .o_cond_code    (o_cond_code),
        .o_target_field (o_target_field),
        .o_label_index  (o_label_index),
        .o_label_new    (o_label_new),
        .o_table_full   (o_table_full)
    );

    always #5 i_clk = ~i_clk;

    // Sample at the edge: a word moves when start is high and busy is low, and a
    // result is valid for the one cycle its strobe is high. Values read here are
    // the ones from before this edge's updates.
    always @(posedge i_clk) begin : monitor
        t_decoded seen;
        if (i_rst_n) begin
            quiet_cycles++;
            if (start && !busy) begin
                tracker.note_word(i_instr_word);
                quiet_cycles = 0;
            end
            if (o_strobe) begin
                seen = {o_recognized, o_mnemonic, o_format, o_reg_first, o_reg_second,
                        o_reg_third, o_imm_value, o_cond_code, o_target_field,
                        o_label_index, o_label_new, o_table_full};
                tracker.check_decode(seen);
                quiet_cycles = 0;
            end
            // Watchdog: nothing moved in either direction for too long.
            if (quiet_cycles >= QUIET_LIMIT) begin
                $display("%0t watchdog expired with %0d results outstanding",
                         $time, tracker.pending_decodes.size());
                $display("FAIL");
                $finish;
            end
        end
    end

    // Place the opcode in the top bits and fill the rest from the given bits.
    function automatic logic [WORD_W-1:0] build_word(input t_mnem m, input logic [31:0] rest);
        t_opcode e;
        e = op_info(m);
        return (32'(e.code) << (32 - e.wid)) | (rest & (32'hFFFF_FFFF >> e.wid));
    endfunction

    // Mostly well-formed words with random content; branches reuse earlier
    // targets often enough to hit stored labels, and fresh ones fill the table.
    function automatic logic [WORD_W-1:0] random_word();
        t_mnem            m;
        logic [TGT_W-1:0] tgt;
        logic [4:0]       low;
        int               sel;
        sel = $urandom_range(0, 99);
        if (sel < 35) begin
            case ($urandom_range(0, 4))
                0:       m = MN_B;
                1:       m = MN_BL;
                2:       m = MN_BCOND;
                3:       m = MN_CBNZ;
                default: m = MN_CBZ;
            endcase
            if (seen_targets.size() > 0 && $urandom_range(0, 99) < 45)
                tgt = seen_targets[$urandom_range(0, seen_targets.size() - 1)];
            else if ($urandom_range(0, 3) == 0)
                tgt = TGT_W'($urandom_range(0, 15));
            else
                tgt = TGT_W'($urandom);
            if (op_info(m).f == FMT_B) begin
                seen_targets.push_back(tgt);
                return build_word(m, {6'b0, tgt});
            end
            // Half of the B.cond words get a condition code from the valid range.
            if (m == MN_BCOND && $urandom_range(0, 1) == 1)
                low = 5'($urandom_range(0, COND_MAX));
            else
                low = 5'($urandom);
            seen_targets.push_back({7'b0, tgt[18:0]});
            return build_word(m, {8'b0, tgt[18:0], low});
        end
        if (sel < 85) begin
            do
                m = t_mnem'($urandom_range(0, NUM_OPS - 1));
            while (op_info(m).f == FMT_B || op_info(m).f == FMT_CB);
            return build_word(m, $urandom);
        end
        if (sel < 93)
            return $urandom;
        // Near miss: a real opcode with one bit of the top eleven flipped.
        m = t_mnem'($urandom_range(0, NUM_OPS - 1));
        return build_word(m, $urandom) ^ (32'h1 << $urandom_range(21, 31));
    endfunction

    function automatic int pick_gap(input int pct);
        int g;
        g = 0;
        while (g < MAX_GAP && $urandom_range(0, 99) < pct)
            g++;
        return g;
    endfunction

    // Present one word and hold it until the block takes it.
    task automatic send_word(input logic [WORD_W-1:0] w);
        i_instr_word <= w;
        start        <= 1'b1;
        @(posedge i_clk);
        while (busy)
            @(posedge i_clk);
    endtask

    // Drop start for the given number of cycles; scramble the word so a stray capture shows.
    task automatic idle_for(input int cycles);
        start        <= 1'b0;
        i_instr_word <= $urandom;
        repeat (cycles) @(posedge i_clk);
    endtask

    initial begin
        i_rst_n      = 1'b0;
        start        = 1'b0;
        i_instr_word = '0;
        quiet_cycles = 0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Every opcode once, alternating all-ones and all-zeros operand bits.
        // This also covers the field extremes and first labels: B storing the
        // widest target, B.cond with condition zero and CBZ both landing on
        // BL's zero target, CBNZ storing the widest CB target.
        for (int i = 0; i < NUM_OPS; i++)
            send_word(build_word(t_mnem'(i), (i % 2 == 0) ? 32'hFFFF_FFFF : 32'h0));
        send_word(32'h0);                                         // matches nothing
        send_word(build_word(MN_BCOND, {8'b0, 19'h00ABC, 5'd13})); // last valid condition
        send_word(build_word(MN_BCOND, {8'b0, 19'h00ABC, 5'd14})); // first bad condition
        send_word(build_word(MN_B, {6'b0, 26'h007FFFF}));          // B hits a CB label
        send_word(build_word(MN_ADDI, {10'b0, 12'h800, 10'h3FF})); // most negative imm
        send_word(build_word(MN_LDUR, {11'b0, 9'h100, 2'b00, 10'h155})); // negative offset

        // Random words in idling phases; the label table fills along the way.
        for (int phase = 0; phase < 4; phase++) begin
            for (int n = 0; n < PHASE_WORDS; n++) begin
                int gap;
                gap = pick_gap(idle_pct[phase]);
                if (gap > 0)
                    idle_for(gap);
                send_word(random_word());
            end
        end
        start <= 1'b0;

        // Drain, then give a late or duplicate result time to show up.
        while (tracker.pending_decodes.size() != 0)
            @(posedge i_clk);
        repeat (LABEL_DEPTH + 4) @(posedge i_clk);
        tracker.close_out();

        $display("Decoded %0d words (%0d branches), checked %0d results, %0d mismatches.",
                 tracker.words, tracker.branches, tracker.results, tracker.mismatches);
        $display("Label table held %0d of %0d targets; %0d branches found it full.",
                 tracker.label_used, LABEL_DEPTH, tracker.full_hits);
        if (tracker.mismatches == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
